@@ src/arpr_pkg.sv @@
// Package for the proxy ARP range responder.
// Holds shared codes, table entry type and controller/datapath interface structs.
// No dependencies.
package arpr_pkg;

   // request operation codes
   localparam logic [1:0] OP_PACKET = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [15:0] ARP_REQUEST_CODE = 16'd1;

   typedef enum logic [2:0] {
      ST_REPLY       = 3'd0,
      ST_NOT_REQUEST = 3'd1,
      ST_NO_MATCH    = 3'd2,
      ST_ADDED       = 3'd3,
      ST_FULL        = 3'd4,
      ST_CLEARED     = 3'd5
   } status_type;

   typedef struct packed {
      logic [31:0] low;
      logic [31:0] high;
      logic [7:0]  port;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_req;
      logic       write_entry;
      logic       clear_count;
      logic       clear_idx;
      logic       inc_idx;
      logic       read_entry;
      logic       load_rsp;
      status_type status;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] op;
      logic       is_request;
      logic       enable;
      logic       count_zero;
      logic       full;
      logic       hit;
      logic       last;
      logic       out_free;
   } dp_sts_type;

endpackage

@@ src/arpr_ctrl.sv @@
// Controller state machine of the proxy ARP range responder.
// Sequences request decode, table scan and response load.
// Depends on arpr_pkg.
module arpr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  arpr_pkg::dp_sts_type   sts,
   output arpr_pkg::dp_cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_CHECK,
      S_EMIT
   } state_type;

   state_type             state_ff, state_in;
   arpr_pkg::status_type  status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= arpr_pkg::ST_NO_MATCH;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      cmd       = '0;
      cmd.status = status_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_EMIT;
            case (sts.op)
               arpr_pkg::OP_PACKET: begin
                  if (!sts.is_request) begin
                     status_in = arpr_pkg::ST_NOT_REQUEST;
                  end else if (!sts.enable || sts.count_zero) begin
                     status_in = arpr_pkg::ST_NO_MATCH;
                  end else begin
                     cmd.clear_idx = 1'b1;
                     state_in      = S_READ;
                  end
               end
               arpr_pkg::OP_ADD: begin
                  if (sts.full) begin
                     status_in = arpr_pkg::ST_FULL;
                  end else begin
                     cmd.write_entry = 1'b1;
                     status_in       = arpr_pkg::ST_ADDED;
                  end
               end
               arpr_pkg::OP_CLEAR: begin
                  cmd.clear_count = 1'b1;
                  status_in       = arpr_pkg::ST_CLEARED;
               end
               default: begin
                  status_in = arpr_pkg::ST_NO_MATCH;
               end
            endcase
         end
         S_READ: begin
            cmd.read_entry = 1'b1;
            state_in       = S_CHECK;
         end
         S_CHECK: begin
            if (sts.hit) begin
               status_in = arpr_pkg::ST_REPLY;
               state_in  = S_EMIT;
            end else if (sts.last) begin
               status_in = arpr_pkg::ST_NO_MATCH;
               state_in  = S_EMIT;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = S_READ;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ src/arpr_dp.sv @@
// Datapath of the proxy ARP range responder.
// Holds request registers, range table memory, scan compare and response register.
// Depends on arpr_pkg.
module arpr_dp #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_wdata,
   input  logic [1:0]           req_op,
   input  logic [7:0]           req_port_id,
   input  logic [47:0]          req_port_mac,
   input  logic [15:0]          req_arp_opcode,
   input  logic [31:0]          req_target_ip,
   input  logic [31:0]          req_sender_ip,
   input  logic [47:0]          req_sender_mac,
   input  logic [7:0]           req_entry_port,
   input  logic [31:0]          req_range_start,
   input  logic [31:0]          req_range_end,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_status,
   output logic [31:0]          rsp_reply_sender_ip,
   output logic [47:0]          rsp_reply_sender_mac,
   output logic [31:0]          rsp_reply_target_ip,
   output logic [47:0]          rsp_reply_target_mac,
   input  arpr_pkg::dp_cmd_type cmd,
   output arpr_pkg::dp_sts_type sts
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   // request registers
   logic [1:0]  op_ff;
   logic [7:0]  port_ff;
   logic [47:0] port_mac_ff;
   logic [15:0] opcode_ff;
   logic [31:0] target_ip_ff;
   logic [31:0] sender_ip_ff;
   logic [47:0] sender_mac_ff;
   arpr_pkg::entry_type new_entry_ff;

   logic                enable_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [IDX_W-1:0]    idx_ff;
   arpr_pkg::entry_type mem [MAX_ENTRIES];
   arpr_pkg::entry_type rd_ff;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [31:0] rsp_sip_ff;
   logic [47:0] rsp_smac_ff;
   logic [31:0] rsp_tip_ff;
   logic [47:0] rsp_tmac_ff;
   logic        out_free;
   logic        is_reply;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff              <= req_op;
         port_ff            <= req_port_id;
         port_mac_ff        <= req_port_mac;
         opcode_ff          <= req_arp_opcode;
         target_ip_ff       <= req_target_ip;
         sender_ip_ff       <= req_sender_ip;
         sender_mac_ff      <= req_sender_mac;
         new_entry_ff.low   <= req_range_start;
         new_entry_ff.high  <= req_range_end;
         new_entry_ff.port  <= req_entry_port;
      end
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         mem[count_ff[IDX_W-1:0]] <= new_entry_ff;
      end
      if (cmd.read_entry) begin
         rd_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         count_ff  <= '0;
         idx_ff    <= '0;
      end else begin
         if (csr_we) begin
            enable_ff <= csr_wdata;
         end
         if (cmd.clear_count) begin
            count_ff <= '0;
         end else if (cmd.write_entry) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.clear_idx) begin
            idx_ff <= '0;
         end else if (cmd.inc_idx) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_reply = (cmd.status == arpr_pkg::ST_REPLY);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.status;
         rsp_sip_ff    <= is_reply ? target_ip_ff  : 32'd0;
         rsp_smac_ff   <= is_reply ? port_mac_ff   : 48'd0;
         rsp_tip_ff    <= is_reply ? sender_ip_ff  : 32'd0;
         rsp_tmac_ff   <= is_reply ? sender_mac_ff : 48'd0;
      end
   end

   always_comb begin
      sts.op         = op_ff;
      sts.is_request = (opcode_ff == arpr_pkg::ARP_REQUEST_CODE);
      sts.enable     = enable_ff;
      sts.count_zero = (count_ff == '0);
      sts.full       = (count_ff == CNT_W'(MAX_ENTRIES));
      sts.hit        = (rd_ff.port == port_ff) && (rd_ff.low <= target_ip_ff)
                       && (target_ip_ff <= rd_ff.high);
      sts.last       = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
      sts.out_free   = out_free;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_reply_sender_ip  = rsp_sip_ff;
   assign rsp_reply_sender_mac = rsp_smac_ff;
   assign rsp_reply_target_ip  = rsp_tip_ff;
   assign rsp_reply_target_mac = rsp_tmac_ff;

endmodule

@@ src/arp_proxy_range_responder.sv @@
// Top level of the proxy ARP range responder.
// Joins the controller (arpr_ctrl) and the datapath (arpr_dp); uses arpr_pkg.
//
// The request channel (req_valid/req_stall) carries one request: an ARP packet
// seen on a port, an add of a port-bound IPv4 range, or a table clear. Every
// request yields exactly one response on rsp_valid/rsp_stall with a status code
// and, for a proxy reply, the four reply address fields (zero for any other
// status). csr_we/csr_wdata write proxy_enable; write it only while idle.
// Sequence: an accepted request is decoded in S_EXEC; with no table scan
// (non-request opcode, disabled, empty table, add, clear, unused op) its
// result goes straight to S_EMIT and into the response register. A scan walks
// the entries in order, each with one registered memory read (S_READ) and one
// compare (S_CHECK), and stops at the first hit or after the last entry. The
// next request is taken only once the response is loaded; the scan loop over
// the single read port of the range table sets the request rate.
// Reset: synchronous, active high. Clears the entry count, proxy_enable and
// the response valid; the table contents are left as they are.
// Back-pressure: while rsp_stall holds, the response stays put; a finished
// result waits in the controller, with req_stall high, until the register frees.
module arp_proxy_range_responder #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_port_id,
   input  logic [47:0] req_port_mac,
   input  logic [15:0] req_arp_opcode,
   input  logic [31:0] req_target_ip,
   input  logic [31:0] req_sender_ip,
   input  logic [47:0] req_sender_mac,
   input  logic [7:0]  req_entry_port,
   input  logic [31:0] req_range_start,
   input  logic [31:0] req_range_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_reply_sender_ip,
   output logic [47:0] rsp_reply_sender_mac,
   output logic [31:0] rsp_reply_target_ip,
   output logic [47:0] rsp_reply_target_mac
);

   arpr_pkg::dp_cmd_type cmd;
   arpr_pkg::dp_sts_type sts;

   // sequence decode, scan and response handoff
   arpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold the request, the range table and the response register
   arpr_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_wdata            (csr_wdata),
      .req_op               (req_op),
      .req_port_id          (req_port_id),
      .req_port_mac         (req_port_mac),
      .req_arp_opcode       (req_arp_opcode),
      .req_target_ip        (req_target_ip),
      .req_sender_ip        (req_sender_ip),
      .req_sender_mac       (req_sender_mac),
      .req_entry_port       (req_entry_port),
      .req_range_start      (req_range_start),
      .req_range_end        (req_range_end),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_reply_sender_ip  (rsp_reply_sender_ip),
      .rsp_reply_sender_mac (rsp_reply_sender_mac),
      .rsp_reply_target_ip  (rsp_reply_target_ip),
      .rsp_reply_target_mac (rsp_reply_target_mac),
      .cmd                  (cmd),
      .sts                  (sts)
   );

endmodule

@@ src/arpr_checker.sv @@
// Port-level checker for the proxy ARP range responder, with its bind.
// Depends on arpr_pkg and the top level arp_proxy_range_responder.
module arpr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_reply_sender_ip,
   input logic [47:0] rsp_reply_sender_mac,
   input logic [31:0] rsp_reply_target_ip,
   input logic [47:0] rsp_reply_target_mac
);

   // drop any response after reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // hold off the next request while one is in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while busy");

   a_non_reply_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != arpr_pkg::ST_REPLY)) |->
      (rsp_reply_sender_ip == '0) && (rsp_reply_sender_mac == '0) &&
      (rsp_reply_target_ip == '0) && (rsp_reply_target_mac == '0))
      else $error("reply fields set on non-reply status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_reply_sender_ip) && $stable(rsp_reply_target_mac))
      else $error("stalled response changed");

endmodule

bind arp_proxy_range_responder arpr_checker u_arpr_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_status           (rsp_status),
   .rsp_reply_sender_ip  (rsp_reply_sender_ip),
   .rsp_reply_sender_mac (rsp_reply_sender_mac),
   .rsp_reply_target_ip  (rsp_reply_target_ip),
   .rsp_reply_target_mac (rsp_reply_target_mac)
);

@@ tb/tb.sv @@
// Self-checking bench for the proxy ARP range responder (arp_proxy_range_responder).
// Holds a range-table predictor in a small class; depends on arpr_pkg and the RTL only.
// Drives directed then random requests under random request gaps and response stalls.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 16;
   // the slowest scan walks the whole table; leave margin for the tail
   localparam int TAIL_CYCLES = 3 + 2 * TABLE_DEPTH + 12;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_REQUESTS = 300;
   localparam int MAX_PRINTED = 40;

   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam logic [15:0] ARP_OP_REPLY = 16'd2;

   typedef struct {
      logic [1:0]  op;
      logic [7:0]  port_id;
      logic [47:0] port_mac;
      logic [15:0] arp_opcode;
      logic [31:0] target_ip;
      logic [31:0] sender_ip;
      logic [47:0] sender_mac;
      logic [7:0]  entry_port;
      logic [31:0] range_start;
      logic [31:0] range_end;
   } proxy_request_type;

   typedef struct {
      arpr_pkg::status_type status;
      logic [31:0]          sender_ip;
      logic [47:0]          sender_mac;
      logic [31:0]          target_ip;
      logic [47:0]          target_mac;
   } proxy_reply_type;

   // Range table predictor plus the queue of replies still owed by the block.
   class proxy_table_type;
      logic [31:0]     range_lo[TABLE_DEPTH];
      logic [31:0]     range_hi[TABLE_DEPTH];
      logic [7:0]      range_port[TABLE_DEPTH];
      int unsigned     entries;
      bit              proxy_on;
      proxy_reply_type reply_q[$];
      int unsigned     errors;

      function new();
         entries  = 0;
         proxy_on = 1'b0;
         errors   = 0;
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= MAX_PRINTED)
            $display("ERROR at %0t ns: %s", $time, what);
      endtask

      // Apply one accepted request to the table and queue the reply it owes.
      function void note_request(proxy_request_type r);
         proxy_reply_type e;
         bit hit;
         e.status     = arpr_pkg::ST_NO_MATCH;
         e.sender_ip  = '0;
         e.sender_mac = '0;
         e.target_ip  = '0;
         e.target_mac = '0;
         hit = 1'b0;
         case (r.op)
            arpr_pkg::OP_PACKET: begin
               if (r.arp_opcode != arpr_pkg::ARP_REQUEST_CODE) begin
                  e.status = arpr_pkg::ST_NOT_REQUEST;
               end else if (proxy_on) begin
                  for (int i = 0; i < entries; i++)
                     if (range_port[i] == r.port_id && range_lo[i] <= r.target_ip &&
                         r.target_ip <= range_hi[i])
                        hit = 1'b1;
                  if (hit) begin
                     e.status     = arpr_pkg::ST_REPLY;
                     e.sender_ip  = r.target_ip;
                     e.sender_mac = r.port_mac;
                     e.target_ip  = r.sender_ip;
                     e.target_mac = r.sender_mac;
                  end
               end
            end
            arpr_pkg::OP_ADD: begin
               if (entries >= TABLE_DEPTH) begin
                  e.status = arpr_pkg::ST_FULL;
               end else begin
                  range_lo[entries]   = r.range_start;
                  range_hi[entries]   = r.range_end;
                  range_port[entries] = r.entry_port;
                  entries++;
                  e.status = arpr_pkg::ST_ADDED;
               end
            end
            arpr_pkg::OP_CLEAR: begin
               entries  = 0;
               e.status = arpr_pkg::ST_CLEARED;
            end
            default: e.status = arpr_pkg::ST_NO_MATCH;
         endcase
         reply_q.push_back(e);
      endfunction

      // Compare one accepted response against the oldest owed reply.
      task check_reply(proxy_reply_type got);
         proxy_reply_type e;
         if (reply_q.size() == 0) begin
            report_mismatch($sformatf("response with status %0d but none owed", got.status));
            return;
         end
         e = reply_q.pop_front();
         if (got.status !== e.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, e.status));
         if (got.sender_ip !== e.sender_ip)
            report_mismatch($sformatf("reply_sender_ip %h, expected %h",
                                      got.sender_ip, e.sender_ip));
         if (got.sender_mac !== e.sender_mac)
            report_mismatch($sformatf("reply_sender_mac %h, expected %h",
                                      got.sender_mac, e.sender_mac));
         if (got.target_ip !== e.target_ip)
            report_mismatch($sformatf("reply_target_ip %h, expected %h",
                                      got.target_ip, e.target_ip));
         if (got.target_mac !== e.target_mac)
            report_mismatch($sformatf("reply_target_mac %h, expected %h",
                                      got.target_mac, e.target_mac));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_op;
   logic [7:0]  req_port_id;
   logic [47:0] req_port_mac;
   logic [15:0] req_arp_opcode;
   logic [31:0] req_target_ip;
   logic [31:0] req_sender_ip;
   logic [47:0] req_sender_mac;
   logic [7:0]  req_entry_port;
   logic [31:0] req_range_start;
   logic [31:0] req_range_end;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_reply_sender_ip;
   logic [47:0] rsp_reply_sender_mac;
   logic [31:0] rsp_reply_target_ip;
   logic [47:0] rsp_reply_target_mac;

   proxy_table_type sb = new();

   bit              req_gaps_on;
   bit              rsp_stalls_on;
   int              stall_left;
   int unsigned     cycle_count;
   proxy_reply_type observed;

   arp_proxy_range_responder #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_op               (req_op),
      .req_port_id          (req_port_id),
      .req_port_mac         (req_port_mac),
      .req_arp_opcode       (req_arp_opcode),
      .req_target_ip        (req_target_ip),
      .req_sender_ip        (req_sender_ip),
      .req_sender_mac       (req_sender_mac),
      .req_entry_port       (req_entry_port),
      .req_range_start      (req_range_start),
      .req_range_end        (req_range_end),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_reply_sender_ip  (rsp_reply_sender_ip),
      .rsp_reply_sender_mac (rsp_reply_sender_mac),
      .rsp_reply_target_ip  (rsp_reply_target_ip),
      .rsp_reply_target_mac (rsp_reply_target_mac)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Idle lengths: mostly short, now and then a long stretch.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [47:0] random_mac();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[47:0];
   endfunction

   // Fill every field with random bits; callers override what the op uses.
   function automatic proxy_request_type noise_request();
      proxy_request_type r;
      r.op          = 2'($urandom);
      r.port_id     = 8'($urandom);
      r.port_mac    = random_mac();
      r.arp_opcode  = 16'($urandom);
      r.target_ip   = $urandom;
      r.sender_ip   = $urandom;
      r.sender_mac  = random_mac();
      r.entry_port  = 8'($urandom);
      r.range_start = $urandom;
      r.range_end   = $urandom;
      return r;
   endfunction

   // Shape an added range: inverted, pinned to either end, single address or a span.
   function automatic void shape_range(ref proxy_request_type r);
      logic [31:0] span;
      case ($urandom_range(0, 9))
         0: begin
            r.range_start = $urandom_range(1, 32'hFFFF_FFFF);
            r.range_end   = $urandom_range(0, r.range_start - 1);
         end
         1: r.range_start = '0;
         2: r.range_end = '1;
         3: r.range_end = r.range_start;
         default: begin
            span = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 1 << 20);
            r.range_end = (r.range_start > 32'hFFFF_FFFF - span) ? 32'hFFFF_FFFF
                                                                 : r.range_start + span;
         end
      endcase
   endfunction

   // Mostly well-formed ARP requests aimed at live table entries, plus adds,
   // the odd clear, unused ops and non-request opcodes as noise.
   function automatic proxy_request_type random_request();
      proxy_request_type r;
      int                pick;
      int                k;
      longint unsigned   span;
      longint unsigned   offset;
      r    = noise_request();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         r.op = arpr_pkg::OP_PACKET;
         if ($urandom_range(0, 9) < 8)
            r.arp_opcode = arpr_pkg::ARP_REQUEST_CODE;
         else if ($urandom_range(0, 1) == 0)
            r.arp_opcode = ARP_OP_REPLY;
         if (sb.entries > 0 && $urandom_range(0, 9) < 7) begin
            k = $urandom_range(0, sb.entries - 1);
            r.port_id = sb.range_port[k];
            if (sb.range_lo[k] <= sb.range_hi[k] && $urandom_range(0, 4) != 0) begin
               span = 64'(sb.range_hi[k]) - 64'(sb.range_lo[k]);
               case ($urandom_range(0, 3))
                  0:       offset = 0;
                  1:       offset = span;
                  default: offset = {$urandom, $urandom} % (span + 1);
               endcase
               r.target_ip = 32'(64'(sb.range_lo[k]) + offset);
            end
         end else begin
            r.port_id = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
         end
      end else if (pick < 95) begin
         r.op = arpr_pkg::OP_ADD;
         if ($urandom_range(0, 9) < 6)
            r.entry_port = 8'($urandom_range(0, 3));
         shape_range(r);
      end else if (pick < 97) begin
         r.op = arpr_pkg::OP_CLEAR;
      end else begin
         r.op = OP_UNUSED;
      end
      return r;
   endfunction

   // Present one request, hold it until taken, then note it and maybe go idle.
   task automatic send_request(input proxy_request_type r);
      int gap;
      req_valid       <= 1'b1;
      req_op          <= r.op;
      req_port_id     <= r.port_id;
      req_port_mac    <= r.port_mac;
      req_arp_opcode  <= r.arp_opcode;
      req_target_ip   <= r.target_ip;
      req_sender_ip   <= r.sender_ip;
      req_sender_mac  <= r.sender_mac;
      req_entry_port  <= r.entry_port;
      req_range_start <= r.range_start;
      req_range_end   <= r.range_end;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(r);
      gap = (req_gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain every owed reply, then write proxy_enable while the block is idle.
   task automatic set_proxy_enable(input bit enable);
      req_valid <= 1'b0;
      while (sb.reply_q.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= enable;
      @(posedge clock);
      csr_we      <= 1'b0;
      sb.proxy_on = enable;
   endtask

   task automatic run_directed();
      proxy_request_type r;
      // empty table, every field zero
      r = noise_request();
      r = '{arpr_pkg::OP_PACKET, 8'h00, 48'h0, arpr_pkg::ARP_REQUEST_CODE, 32'h0, 32'h0,
            48'h0, 8'h00, 32'h0, 32'h0};
      send_request(r);
      // opcodes other than request pass on
      r = noise_request();
      r.op = arpr_pkg::OP_PACKET;
      r.arp_opcode = 16'h0000;
      send_request(r);
      r.arp_opcode = 16'hFFFF;
      send_request(r);
      r.arp_opcode = ARP_OP_REPLY;
      send_request(r);
      // unused op changes nothing
      r = noise_request();
      r.op = OP_UNUSED;
      send_request(r);
      // whole address space on port 0, an inverted range and a single address on port 255
      r = noise_request();
      r.op = arpr_pkg::OP_ADD;
      r.entry_port = 8'h00;
      r.range_start = 32'h0000_0000;
      r.range_end = 32'hFFFF_FFFF;
      send_request(r);
      r.entry_port = 8'hFF;
      r.range_start = 32'd20;
      r.range_end = 32'd10;
      send_request(r);
      r.range_start = 32'd5;
      r.range_end = 32'd5;
      send_request(r);
      // hit on port 0 with the MAC, IP, entry port and range fields at all ones
      r = '{arpr_pkg::OP_PACKET, 8'h00, '1, arpr_pkg::ARP_REQUEST_CODE, '1, '1, '1, '1, '1,
            '1};
      send_request(r);
      // inverted range never matches; the single address on port 255 does
      r = noise_request();
      r.op = arpr_pkg::OP_PACKET;
      r.arp_opcode = arpr_pkg::ARP_REQUEST_CODE;
      r.port_id = 8'hFF;
      r.target_ip = 32'd15;
      send_request(r);
      r.target_ip = 32'd5;
      send_request(r);
      // right address, wrong port
      r.port_id = 8'h01;
      send_request(r);
      // fill the table, then one add too many
      while (sb.entries < TABLE_DEPTH) begin
         r = noise_request();
         r.op = arpr_pkg::OP_ADD;
         r.entry_port = 8'($urandom_range(0, 3));
         shape_range(r);
         send_request(r);
      end
      r.op = arpr_pkg::OP_ADD;
      send_request(r);
      // proxying off: a request that would hit gets no reply
      set_proxy_enable(1'b0);
      r = noise_request();
      r.op = arpr_pkg::OP_PACKET;
      r.arp_opcode = arpr_pkg::ARP_REQUEST_CODE;
      r.port_id = 8'h00;
      send_request(r);
      r = noise_request();
      r.op = arpr_pkg::OP_CLEAR;
      send_request(r);
   endtask

   // Response side: check each accepted response, then pick the next stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            observed.status     = arpr_pkg::status_type'(rsp_status);
            observed.sender_ip  = rsp_reply_sender_ip;
            observed.sender_mac = rsp_reply_sender_mac;
            observed.target_ip  = rsp_reply_target_ip;
            observed.target_mac = rsp_reply_target_mac;
            sb.check_reply(observed);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_stalls_on && $urandom_range(0, 4) == 0) begin
            stall_left = pick_gap() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      cycle_count     = 0;
      req_gaps_on     = 1'b0;
      rsp_stalls_on   = 1'b0;
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_wdata       <= 1'b0;
      req_valid       <= 1'b0;
      req_op          <= arpr_pkg::OP_PACKET;
      req_port_id     <= '0;
      req_port_mac    <= '0;
      req_arp_opcode  <= '0;
      req_target_ip   <= '0;
      req_sender_ip   <= '0;
      req_sender_mac  <= '0;
      req_entry_port  <= '0;
      req_range_start <= '0;
      req_range_end   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass with proxying on, idling on both sides
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      set_proxy_enable(1'b1);
      run_directed();

      // random phases; vary proxy_enable and idling between them
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_proxy_enable(phase % 3 != 1);
         req_gaps_on   = (phase % 2 == 0);
         rsp_stalls_on = (phase % 3 != 2);
         for (int n = 0; n < PHASE_REQUESTS; n++)
            send_request(random_request());
      end

      // drain, then let anything stray show up before the verdict
      req_valid <= 1'b0;
      while (sb.reply_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
